// ===== rtl/lspd_pkg.sv =====
// Package for the LSB payload deframer: config/result types, parse phases,
// register indexes, reset defaults and the token character helper.
// No dependencies.
package lspd_pkg;

    localparam int unsigned MAX_TOKEN_CHARS = 8;

    localparam logic [2:0] CFG_HEADER_SKIP = 3'd0;
    localparam logic [2:0] CFG_MAGIC_LEN   = 3'd1;
    localparam logic [2:0] CFG_MAGIC_WORD  = 3'd2;
    localparam logic [2:0] CFG_EXT_LEN     = 3'd3;
    localparam logic [2:0] CFG_EXT_WORD    = 3'd4;

    localparam logic [7:0]  RST_HEADER_SKIP = 8'd54;
    localparam logic [3:0]  RST_MAGIC_LEN   = 4'd2;
    localparam logic [63:0] RST_MAGIC_WORD  = 64'h0000_0000_0000_2A23;
    localparam logic [3:0]  RST_EXT_LEN     = 4'd4;
    localparam logic [63:0] RST_EXT_WORD    = 64'h0000_0000_7478_742E;

    localparam logic [1:0] ST_PAYLOAD     = 2'd0;
    localparam logic [1:0] ST_EXT_BAD     = 2'd1;
    localparam logic [1:0] ST_EXT_LEN_BAD = 2'd2;

    typedef enum logic [6:0] {
        PH_SKIP    = 7'b0000001,
        PH_MAGIC   = 7'b0000010,
        PH_EXTLEN  = 7'b0000100,
        PH_EXT     = 7'b0001000,
        PH_PAYLEN  = 7'b0010000,
        PH_PAYLOAD = 7'b0100000,
        PH_DONE    = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [7:0]  header_skip;
        logic [3:0]  magic_len;
        logic [63:0] magic_word;
        logic [3:0]  ext_len;
        logic [63:0] ext_word;
    } t_cfg;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_last;
        logic       magic_ok;
        logic [1:0] status;
    } t_result;

    function automatic logic [3:0] eff_len(input logic [3:0] len);
        return (len > 4'(MAX_TOKEN_CHARS)) ? 4'(MAX_TOKEN_CHARS) : len;
    endfunction

    function automatic logic [7:0] token_char(input logic [63:0] word, input logic [2:0] idx);
        logic [63:0] sh;
        sh = word >> {idx, 3'b000};
        return sh[7:0];
    endfunction

endpackage

// ===== rtl/lspd_ifs.sv =====
// Valid/ready channel interfaces for the LSB payload deframer.
// Depends on nothing; payload widths follow the block's fields.
interface lspd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] image_byte;
    logic       frame_start;

    modport source (output valid, output image_byte, output frame_start, input ready);
    modport sink   (input valid, input image_byte, input frame_start, output ready);
endinterface

interface lspd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_last;
    logic       magic_ok;
    logic [1:0] status;

    modport source (output valid, output out_byte, output is_last, output magic_ok,
                    output status, input ready);
    modport sink   (input valid, input out_byte, input is_last, input magic_ok,
                    input status, output ready);
endinterface

// ===== rtl/lspd_parser.sv =====
// Parse state and one-bit-per-step field decoder of the LSB payload deframer.
// Depends on lspd_pkg.
module lspd_parser import lspd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_bit,
    input  logic    i_frame_start,
    input  t_cfg    i_cfg,
    output logic    o_emit,
    output t_result o_result
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_skip_count, n_skip_count;
    logic [4:0]  r_bit_count, n_bit_count;
    logic [31:0] r_bit_shift, n_bit_shift;
    logic [3:0]  r_field_index, n_field_index;
    logic        r_magic_match, n_magic_match;
    logic [31:0] r_payload_left, n_payload_left;

    logic [3:0]  mlen, elen;
    logic        go, wide, word_done;
    logic [31:0] cur;

    always_comb begin
        n_phase        = r_phase;
        n_skip_count   = r_skip_count;
        n_bit_count    = r_bit_count;
        n_bit_shift    = r_bit_shift;
        n_field_index  = r_field_index;
        n_magic_match  = r_magic_match;
        n_payload_left = r_payload_left;
        o_emit         = 1'b0;
        o_result       = '0;
        mlen           = eff_len(i_cfg.magic_len);
        elen           = eff_len(i_cfg.ext_len);
        go             = 1'b1;
        wide           = 1'b0;
        word_done      = 1'b0;
        cur            = '0;

        if (i_frame_start) begin
            n_phase        = PH_SKIP;
            n_skip_count   = '0;
            n_bit_count    = '0;
            n_bit_shift    = '0;
            n_field_index  = '0;
            n_magic_match  = 1'b1;
            n_payload_left = '0;
        end

        if (n_phase == PH_SKIP) begin
            if (n_skip_count < i_cfg.header_skip) begin
                n_skip_count = n_skip_count + 8'd1;
                go = 1'b0;
            end else begin
                n_phase = (mlen != 4'd0) ? PH_MAGIC : PH_EXTLEN;
            end
        end
        if (n_phase == PH_DONE) begin
            go = 1'b0;
        end

        if (go) begin
            wide      = (n_phase == PH_EXTLEN) || (n_phase == PH_PAYLEN);
            cur       = n_bit_shift | ({31'b0, i_bit} << n_bit_count);
            word_done = wide ? (n_bit_count == 5'd31) : (n_bit_count >= 5'd7);
            if (!word_done) begin
                n_bit_shift = cur;
                n_bit_count = n_bit_count + 5'd1;
            end else begin
                n_bit_shift = '0;
                n_bit_count = '0;
                case (n_phase)
                    PH_MAGIC: begin
                        if (cur != {24'b0, token_char(i_cfg.magic_word, n_field_index[2:0])}) begin
                            n_magic_match = 1'b0;
                        end
                        n_field_index = n_field_index + 4'd1;
                        if (n_field_index >= mlen) begin
                            n_field_index = '0;
                            n_phase = PH_EXTLEN;
                        end
                    end
                    PH_EXTLEN: begin
                        if (cur != {28'b0, elen}) begin
                            n_phase = PH_DONE;
                            o_emit = 1'b1;
                            o_result.status = ST_EXT_LEN_BAD;
                        end else begin
                            n_phase = (elen != 4'd0) ? PH_EXT : PH_PAYLEN;
                        end
                    end
                    PH_EXT: begin
                        if (cur != {24'b0, token_char(i_cfg.ext_word, n_field_index[2:0])}) begin
                            n_phase = PH_DONE;
                            o_emit = 1'b1;
                            o_result.status = ST_EXT_BAD;
                        end else begin
                            n_field_index = n_field_index + 4'd1;
                            if (n_field_index >= elen) begin
                                n_field_index = '0;
                                n_phase = PH_PAYLEN;
                            end
                        end
                    end
                    PH_PAYLEN: begin
                        n_payload_left = cur;
                        n_phase = (cur != 32'd0) ? PH_PAYLOAD : PH_DONE;
                    end
                    PH_PAYLOAD: begin
                        n_payload_left = n_payload_left - 32'd1;
                        if (n_payload_left == 32'd0) begin
                            n_phase = PH_DONE;
                        end
                        o_emit = 1'b1;
                        o_result.out_byte = cur[7:0];
                        o_result.is_last = (n_payload_left == 32'd0);
                        o_result.status = ST_PAYLOAD;
                    end
                    default: begin
                        n_phase = PH_DONE;
                    end
                endcase
            end
        end
        o_result.magic_ok = n_magic_match;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_SKIP;
            r_skip_count   <= '0;
            r_bit_count    <= '0;
            r_bit_shift    <= '0;
            r_field_index  <= '0;
            r_magic_match  <= 1'b1;
            r_payload_left <= '0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_skip_count   <= n_skip_count;
            r_bit_count    <= n_bit_count;
            r_bit_shift    <= n_bit_shift;
            r_field_index  <= n_field_index;
            r_magic_match  <= n_magic_match;
            r_payload_left <= n_payload_left;
        end
    end

endmodule

// ===== rtl/lsb_stego_payload_deframer.sv =====
// Top level of the LSB payload deframer: config registers, input register,
// result register and the parser. Depends on lspd_pkg, lspd_ifs, lspd_parser.
//
// Usage:
//   i_in carries one carrier image byte per transaction; only bit 0 holds
//   hidden data. frame_start = 1 restarts parsing with that byte as byte 0.
//   o_out carries payload bytes (status 0, is_last on the final one) or a
//   single error transaction (status 1 or 2) after which the frame is ignored
//   until the next frame_start. magic_ok reports the magic comparison.
//   Config: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 header_skip,
//   1 magic_len, 2 magic_word, 3 ext_len, 4 ext_word); write only when idle.
// Timing:
//   One input transaction per cycle sustained while o_out is not stalled. A
//   result is registered on o_out after its byte passes the input register, then the result register.
//   If o_out is stalled, the held input byte waits and i_in.ready drops once
//   both registers are occupied; nothing is dropped.
// Reset:
//   Synchronous active-low i_rst_n restores register defaults and returns the
//   parser to the header-skip phase with both pipeline registers empty.
module lsb_stego_payload_deframer import lspd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lspd_in_if.sink     i_in,
    lspd_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    t_cfg    r_cfg;
    logic    r_s1_valid;
    logic    r_s1_bit;
    logic    r_s1_fs;
    logic    r_out_valid;
    t_result r_out;

    logic    adv;
    logic    emit;
    t_result result;

    assign adv        = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || adv;

    lspd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (adv),
        .i_bit         (r_s1_bit),
        .i_frame_start (r_s1_fs),
        .i_cfg         (r_cfg),
        .o_emit        (emit),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_skip <= RST_HEADER_SKIP;
            r_cfg.magic_len   <= RST_MAGIC_LEN;
            r_cfg.magic_word  <= RST_MAGIC_WORD;
            r_cfg.ext_len     <= RST_EXT_LEN;
            r_cfg.ext_word    <= RST_EXT_WORD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HEADER_SKIP: r_cfg.header_skip <= i_cfg_data[7:0];
                CFG_MAGIC_LEN:   r_cfg.magic_len   <= i_cfg_data[3:0];
                CFG_MAGIC_WORD:  r_cfg.magic_word  <= i_cfg_data;
                CFG_EXT_LEN:     r_cfg.ext_len     <= i_cfg_data[3:0];
                CFG_EXT_WORD:    r_cfg.ext_word    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_bit <= i_in.image_byte[0];
            r_s1_fs  <= i_in.frame_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_out <= result;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out.out_byte;
    assign o_out.is_last  = r_out.is_last;
    assign o_out.magic_ok = r_out.magic_ok;
    assign o_out.status   = r_out.status;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for lsb_stego_payload_deframer: builds carrier frames with hidden LSB
// streams, tracks the parse in a local model, checks every payload/error transaction.
// Depends on lspd_pkg, lspd_ifs (lspd_in_if, lspd_out_if) and the deframer RTL.
module tb;
    import lspd_pkg::*;

    typedef struct packed {
        logic [7:0] image_byte;
        logic       frame_start;
    } t_carrier;

    typedef enum int {FL_NONE, FL_MAGIC, FL_EXTLEN, FL_EXTCHAR, FL_CUT} t_frame_flaw;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    lspd_in_if  in_ch ();
    lspd_out_if out_ch ();

    lsb_stego_payload_deframer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_carrier pending_bytes[$];
    t_carrier frame_buf[$];
    t_result  expected_deframed[$];

    int items_queued    = 0;
    int items_taken     = 0;
    int n_errors        = 0;
    int src_gap         = 0;
    int snk_gap         = 0;
    int snk_hold        = 0;
    bit src_idle_on     = 1'b1;
    bit snk_idle_on     = 1'b1;
    bit stall_req       = 1'b0;
    bit stall_ack       = 1'b0;

    // local copy of the registers and parse state
    t_cfg        cfg_now;
    t_phase      ph;
    logic [7:0]  skip_cnt;
    logic [4:0]  bit_cnt;
    logic [31:0] shreg;
    logic [3:0]  fidx;
    logic        magic_good;
    logic [31:0] pay_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int token_count(logic [3:0] len);
        return (len > 4'(MAX_TOKEN_CHARS)) ? MAX_TOKEN_CHARS : int'(len);
    endfunction

    task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
        n_errors++;
        $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    function automatic void restart_parse();
        ph         = PH_SKIP;
        skip_cnt   = '0;
        bit_cnt    = '0;
        shreg      = '0;
        fidx       = '0;
        magic_good = 1'b1;
        pay_left   = '0;
    endfunction

    function automatic void push_result(logic [7:0] b, logic last, logic [1:0] st);
        t_result r;
        r.out_byte = b;
        r.is_last  = last;
        r.magic_ok = magic_good;
        r.status   = st;
        expected_deframed.push_back(r);
    endfunction

    function automatic void deframe_byte(logic [7:0] b, logic fs);
        int          mlen, elen, width;
        logic [31:0] val;
        mlen = token_count(cfg_now.magic_len);
        elen = token_count(cfg_now.ext_len);
        if (fs)
            restart_parse();
        if (ph == PH_SKIP) begin
            if (skip_cnt < cfg_now.header_skip) begin
                skip_cnt++;
                return;
            end
            ph = (mlen != 0) ? PH_MAGIC : PH_EXTLEN;
        end
        if (ph == PH_DONE)
            return;
        width = (ph == PH_EXTLEN || ph == PH_PAYLEN) ? 32 : 8;
        shreg[bit_cnt] = b[0];
        if (int'(bit_cnt) + 1 < width) begin
            bit_cnt++;
            return;
        end
        val     = shreg;
        shreg   = '0;
        bit_cnt = '0;
        case (ph)
            PH_MAGIC: begin
                if (val != 32'(cfg_now.magic_word[{fidx[2:0], 3'b000} +: 8]))
                    magic_good = 1'b0;
                fidx++;
                if (int'(fidx) >= mlen) begin
                    fidx = '0;
                    ph   = PH_EXTLEN;
                end
            end
            PH_EXTLEN: begin
                if (val != 32'(elen)) begin
                    ph = PH_DONE;
                    push_result(8'h00, 1'b0, ST_EXT_LEN_BAD);
                end else begin
                    ph = (elen != 0) ? PH_EXT : PH_PAYLEN;
                end
            end
            PH_EXT: begin
                if (val != 32'(cfg_now.ext_word[{fidx[2:0], 3'b000} +: 8])) begin
                    ph = PH_DONE;
                    push_result(8'h00, 1'b0, ST_EXT_BAD);
                end else begin
                    fidx++;
                    if (int'(fidx) >= elen) begin
                        fidx = '0;
                        ph   = PH_PAYLEN;
                    end
                end
            end
            PH_PAYLEN: begin
                pay_left = val;
                ph = (val != 0) ? PH_PAYLOAD : PH_DONE;
            end
            PH_PAYLOAD: begin
                pay_left--;
                if (pay_left == 0)
                    ph = PH_DONE;
                push_result(val[7:0], pay_left == 0, ST_PAYLOAD);
            end
            default: ;
        endcase
    endfunction

    // carrier byte source
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                deframe_byte(in_ch.image_byte, in_ch.frame_start);
                items_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    in_ch.valid <= 1'b0;
                end else if (pending_bytes.size() == 0) begin
                    in_ch.valid <= 1'b0;
                end else if (src_idle_on && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(0, 4);
                    in_ch.valid <= 1'b0;
                end else begin
                    in_ch.valid       <= 1'b1;
                    in_ch.image_byte  <= pending_bytes[0].image_byte;
                    in_ch.frame_start <= pending_bytes[0].frame_start;
                    void'(pending_bytes.pop_front());
                end
            end
        end
    end

    // result sink and checker
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_deframed.size() == 0) begin
                    note_mismatch("unexpected transaction", 64'(out_ch.out_byte), '0);
                end else begin
                    want = expected_deframed.pop_front();
                    if (out_ch.out_byte !== want.out_byte)
                        note_mismatch("out_byte", 64'(out_ch.out_byte), 64'(want.out_byte));
                    if (out_ch.is_last !== want.is_last)
                        note_mismatch("is_last", 64'(out_ch.is_last), 64'(want.is_last));
                    if (out_ch.magic_ok !== want.magic_ok)
                        note_mismatch("magic_ok", 64'(out_ch.magic_ok), 64'(want.magic_ok));
                    if (out_ch.status !== want.status)
                        note_mismatch("status", 64'(out_ch.status), 64'(want.status));
                end
            end
            if (snk_hold > 0) begin
                snk_hold--;
                out_ch.ready <= 1'b0;
            end else if (stall_req != stall_ack) begin
                stall_ack = stall_req;
                snk_hold  = 119;
                out_ch.ready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap--;
                out_ch.ready <= 1'b0;
            end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
                snk_gap = $urandom_range(0, 4);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic wait_drained();
        while (items_taken != items_queued || expected_deframed.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_HEADER_SKIP: cfg_now.header_skip = data[7:0];
            CFG_MAGIC_LEN:   cfg_now.magic_len   = data[3:0];
            CFG_MAGIC_WORD:  cfg_now.magic_word  = data;
            CFG_EXT_LEN:     cfg_now.ext_len     = data[3:0];
            CFG_EXT_WORD:    cfg_now.ext_word    = data;
            default: ;
        endcase
    endtask

    // unused upper bits of the narrow registers get random junk
    task automatic program_regs(logic [7:0] skip, logic [3:0] mlen, logic [63:0] mword,
                                logic [3:0] elen, logic [63:0] eword);
        write_reg(CFG_HEADER_SKIP, {32'($urandom), 24'($urandom), skip});
        write_reg(CFG_MAGIC_LEN, {32'($urandom), 28'($urandom), mlen});
        write_reg(CFG_MAGIC_WORD, mword);
        write_reg(CFG_EXT_LEN, {32'($urandom), 28'($urandom), elen});
        write_reg(CFG_EXT_WORD, eword);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic void push_raw(logic [7:0] b);
        t_carrier c;
        c.image_byte  = b;
        c.frame_start = 1'b0;
        frame_buf.push_back(c);
    endfunction

    function automatic void push_hidden(logic [31:0] v, int nbits);
        for (int i = 0; i < nbits; i++)
            push_raw({7'($urandom), v[i]});
    endfunction

    function automatic void build_frame(t_frame_flaw flaw, logic [31:0] pay_len, int pay_bytes);
        int          ml, el, bad;
        logic [31:0] len_field;
        logic [7:0]  ch;
        frame_buf.delete();
        ml = token_count(cfg_now.magic_len);
        el = token_count(cfg_now.ext_len);
        repeat (cfg_now.header_skip) push_raw(8'($urandom));
        bad = (flaw == FL_MAGIC && ml > 0) ? int'($urandom_range(0, ml - 1)) : -1;
        for (int i = 0; i < ml; i++) begin
            ch = cfg_now.magic_word[i*8 +: 8];
            if (i == bad)
                ch ^= 8'($urandom_range(1, 255));
            push_hidden(32'(ch), 8);
        end
        if (flaw == FL_EXTLEN) begin
            len_field = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 16));
            if (len_field == 32'(el))
                len_field++;
            push_hidden(len_field, 32);
        end else begin
            push_hidden(32'(el), 32);
            bad = (flaw == FL_EXTCHAR && el > 0) ? int'($urandom_range(0, el - 1)) : -1;
            for (int i = 0; i < el; i++) begin
                ch = cfg_now.ext_word[i*8 +: 8];
                if (i == bad)
                    ch ^= 8'($urandom_range(1, 255));
                push_hidden(32'(ch), 8);
                if (i == bad)
                    break;
            end
            if (bad < 0) begin
                push_hidden(pay_len, 32);
                for (int i = 0; i < pay_bytes; i++)
                    push_hidden((i == 0) ? 32'h00 : (i == 1) ? 32'hFF : 32'($urandom), 8);
            end
        end
        repeat ($urandom_range(0, 3)) push_raw(8'($urandom));
        if (flaw == FL_CUT) begin
            bad = $urandom_range(1, frame_buf.size());
            while (frame_buf.size() > bad)
                void'(frame_buf.pop_back());
        end
        frame_buf[0].frame_start = 1'b1;
    endfunction

    task automatic send_part(int lo, int hi);
        for (int i = lo; i < hi; i++) begin
            pending_bytes.push_back(frame_buf[i]);
            items_queued++;
        end
    endtask

    task automatic queue_frame(t_frame_flaw flaw, logic [31:0] pay_len, int pay_bytes);
        build_frame(flaw, pay_len, pay_bytes);
        send_part(0, frame_buf.size());
    endtask

    initial begin
        int          split, frames, r, n;
        logic [7:0]  hs;
        t_frame_flaw flaw;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        in_ch.valid       = 1'b0;
        in_ch.image_byte  = '0;
        in_ch.frame_start = 1'b0;
        out_ch.ready      = 1'b0;
        cfg_now.header_skip = RST_HEADER_SKIP;
        cfg_now.magic_len   = RST_MAGIC_LEN;
        cfg_now.magic_word  = RST_MAGIC_WORD;
        cfg_now.ext_len     = RST_EXT_LEN;
        cfg_now.ext_word    = RST_EXT_WORD;
        restart_parse();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults; sender stops mid-payload until all results are out
        build_frame(FL_NONE, 4, 4);
        split = frame_buf.size() - 20;
        send_part(0, split);
        wait_drained();
        send_part(split, frame_buf.size());
        queue_frame(FL_CUT, 5, 5);
        queue_frame(FL_MAGIC, 2, 2);
        wait_drained();

        // empty magic and extension, zero header, zero-length payload, bad extension length,
        // huge payload length cut short by a new frame, then a long stall on the sink
        program_regs(8'd0, 4'd0, {$urandom, $urandom}, 4'd0, {$urandom, $urandom});
        queue_frame(FL_NONE, 0, 0);
        queue_frame(FL_EXTLEN, 1, 1);
        queue_frame(FL_NONE, 32'h8000_0001, 5);
        queue_frame(FL_NONE, 24, 24);
        while (items_taken < items_queued - 150)
            @(posedge i_clk);
        stall_req <= ~stall_req;
        wait_drained();

        // longest header, over-long tokens
        program_regs(8'd255, 4'd15, {$urandom, $urandom}, 4'd15, {$urandom, $urandom});
        queue_frame(FL_NONE, 1, 1);
        wait_drained();

        frames = 0;
        while (frames < 3 || items_queued < 1400) begin
            if (frames % 4 == 0) begin
                wait_drained();
                src_idle_on = ($urandom_range(0, 3) != 0);
                snk_idle_on = ($urandom_range(0, 3) != 0);
                r  = $urandom_range(0, 9);
                hs = (r == 0) ? 8'd255 : (r == 1) ? 8'($urandom) : 8'($urandom_range(0, 10));
                program_regs(hs, 4'($urandom_range(0, 15)), {$urandom, $urandom},
                             4'($urandom_range(0, 15)), {$urandom, $urandom});
            end
            r = $urandom_range(0, 99);
            if (r < 8) begin
                // noise with stray frame starts
                frame_buf.delete();
                repeat ($urandom_range(1, 24)) push_raw(8'($urandom));
                foreach (frame_buf[i])
                    frame_buf[i].frame_start = ($urandom_range(0, 5) == 0);
                send_part(0, frame_buf.size());
            end else begin
                r    = $urandom_range(0, 99);
                flaw = (r < 60) ? FL_NONE : (r < 70) ? FL_MAGIC : (r < 78) ? FL_EXTLEN :
                       (r < 86) ? FL_EXTCHAR : FL_CUT;
                if ($urandom_range(0, 15) == 0) begin
                    n = $urandom_range(1, 6);
                    queue_frame(flaw, {1'b1, 31'($urandom)}, n);
                end else begin
                    n = $urandom_range(0, 12);
                    queue_frame(flaw, 32'(n), n);
                end
            end
            frames++;
        end

        wait_drained();
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        program_regs(8'd0, 4'd0, {$urandom, $urandom}, 4'd0, {$urandom, $urandom});
        queue_frame(FL_NONE, 6, 6);
        queue_frame(FL_NONE, 3, 3);
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (expected_deframed.size() != 0)
            note_mismatch("transactions never delivered", 64'(expected_deframed.size()), '0);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lspd_pkg.sv
rtl/lspd_ifs.sv
rtl/lspd_parser.sv
rtl/lsb_stego_payload_deframer.sv
tb/tb.sv
